FILE: hw/rtl/okl_pkg.sv
package okl_pkg;

  localparam int LIST_DEPTH = 16;
  localparam int AW = $clog2(LIST_DEPTH);
  localparam int CW = $clog2(LIST_DEPTH + 1);

  localparam int OP_W = 2;
  localparam int KEY_W = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W = 5;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_DELETE     = 2'd2,
    OP_NOP        = 2'd3
  } op_e_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_DONE      = 2'd0,
    STS_FULL      = 2'd1,
    STS_NOT_FOUND = 2'd2,
    STS_EMPTY     = 2'd3
  } status_e_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SHIFT,
    ST_RESULT
  } state_t;

  typedef struct packed {
    status_e_t        status;
    logic [CW-1:0]    count;
    logic [KEY_W-1:0] front_key;
    logic [KEY_W-1:0] back_key;
  } result_t;

  // physical slot of logical position off, counted from the front slot
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                             input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (AW+1)'(LIST_DEPTH)) begin
      sum = sum - (AW+1)'(LIST_DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] base);
    logic [AW-1:0] res;
    if (base == '0) begin
      res = AW'(LIST_DEPTH - 1);
    end else begin
      res = base - AW'(1);
    end
    return res;
  endfunction

endpackage

FILE: hw/rtl/okl_ram.sv
module okl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: hw/rtl/okl_ctrl.sv
module okl_ctrl
  import okl_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  op_e_t            req_op,
  input  logic [KEY_W-1:0] req_key,
  output logic             res_valid,
  input  logic             res_take,
  output result_t          res
);

  state_t           state, state_next;
  logic [KEY_W-1:0] key_q, key_q_next;
  logic [CW-1:0]    count, count_next;
  logic [AW-1:0]    head, head_next;
  logic [AW-1:0]    idx, idx_next;
  logic [KEY_W-1:0] front, front_next;
  logic [KEY_W-1:0] back, back_next;
  logic [KEY_W-1:0] prev, prev_next;
  status_e_t        status, status_next;

  logic             ram_we;
  logic [AW-1:0]    wr_addr;
  logic [KEY_W-1:0] wr_data;
  logic [AW-1:0]    rd_addr;
  logic [KEY_W-1:0] rd_data;

  logic             full;
  logic             empty;
  logic             is_push;
  logic [CW:0]      idx_p1;
  logic [CW:0]      idx_p2;

  assign full    = (count == CW'(LIST_DEPTH));
  assign empty   = (count == '0);
  assign is_push = (req_op == OP_PUSH_FRONT) || (req_op == OP_PUSH_BACK);
  assign idx_p1  = (CW+1)'(idx) + (CW+1)'(1);
  assign idx_p2  = (CW+1)'(idx) + (CW+1)'(2);

  okl_ram #(
    .WIDTH (KEY_W),
    .DEPTH (LIST_DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      count  <= '0;
      head   <= '0;
      status <= STS_DONE;
    end else begin
      state  <= state_next;
      count  <= count_next;
      head   <= head_next;
      status <= status_next;
    end
  end

  always_ff @(posedge clk) begin
    key_q <= key_q_next;
    idx   <= idx_next;
    front <= front_next;
    back  <= back_next;
    prev  <= prev_next;
  end

  always_comb begin
    state_next  = state;
    key_q_next  = key_q;
    count_next  = count;
    head_next   = head;
    idx_next    = idx;
    front_next  = front;
    back_next   = back;
    prev_next   = prev;
    status_next = status;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          key_q_next = req_key;
          idx_next   = '0;
          case (req_op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
              state_next = ST_RESULT;
              if (full) begin
                status_next = STS_FULL;
              end else begin
                status_next = STS_DONE;
                count_next  = count + CW'(1);
                if (req_op == OP_PUSH_FRONT) begin
                  head_next  = wrap_dec(head);
                  front_next = req_key;
                  if (empty) begin
                    back_next = req_key;
                  end
                end else begin
                  back_next = req_key;
                  if (empty) begin
                    front_next = req_key;
                  end
                end
              end
            end
            OP_DELETE: begin
              if (empty) begin
                status_next = STS_EMPTY;
                state_next  = ST_RESULT;
              end else begin
                state_next = ST_SEARCH;
              end
            end
            default: begin
              status_next = STS_DONE;
              state_next  = ST_RESULT;
            end
          endcase
        end
      end
      ST_SEARCH: begin
        prev_next = rd_data;
        if (rd_data == key_q) begin
          if (idx_p1 < (CW+1)'(count)) begin
            state_next = ST_SHIFT;
          end else begin
            back_next   = prev;
            count_next  = count - CW'(1);
            status_next = STS_DONE;
            state_next  = ST_RESULT;
          end
        end else if (idx_p1 < (CW+1)'(count)) begin
          idx_next = idx + AW'(1);
        end else begin
          status_next = STS_NOT_FOUND;
          state_next  = ST_RESULT;
        end
      end
      ST_SHIFT: begin
        if (idx == '0) begin
          front_next = rd_data;
        end
        if (idx_p2 < (CW+1)'(count)) begin
          idx_next = idx + AW'(1);
        end else begin
          count_next  = count - CW'(1);
          status_next = STS_DONE;
          state_next  = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (res_take) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    req_stall = (state != ST_IDLE);
    res_valid = (state == ST_RESULT);
    ram_we    = 1'b0;
    wr_addr   = wrap_add(head, idx);
    wr_data   = rd_data;
    rd_addr   = wrap_add(head, idx_p1[AW-1:0]);
    case (state)
      ST_IDLE: begin
        rd_addr = head;
        wr_data = req_key;
        if (req_op == OP_PUSH_FRONT) begin
          wr_addr = wrap_dec(head);
        end else begin
          wr_addr = wrap_add(head, count[AW-1:0]);
        end
        ram_we = req_valid && is_push && !full;
      end
      ST_SEARCH: begin
        rd_addr = wrap_add(head, idx_p1[AW-1:0]);
      end
      ST_SHIFT: begin
        ram_we  = 1'b1;
        rd_addr = wrap_add(head, idx_p2[AW-1:0]);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  assign res.status    = status;
  assign res.count     = count;
  assign res.front_key = empty ? '0 : front;
  assign res.back_key  = empty ? '0 : back;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(LIST_DEPTH))
    else $error("occupancy above depth");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && req_valid && is_push && !full)
      |=> count == $past(count) + CW'(1))
    else $error("push did not grow occupancy");

  a_search_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH) |-> ((CW+1)'(idx) < (CW+1)'(count)))
    else $error("search index past back");

  a_no_write_search: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH || state == ST_RESULT) |-> !ram_we)
    else $error("write during search or result");

  a_delete_shrinks: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH && rd_data == key_q && idx_p1 >= (CW+1)'(count))
      |=> count == $past(count) - CW'(1))
    else $error("delete of back key did not shrink occupancy");

endmodule

FILE: hw/rtl/ordered_key_list_insert_delete_unit.sv
// Ordered key list: a bounded sequence of up to LIST_DEPTH signed keys.
// Request channel (req_valid, req_stall, operation, key): insert at front,
// insert at back, delete first key from the front that matches, or no-op.
// Response channel (rsp_valid, rsp_stall, status, count, front_key,
// back_key): one transaction per request, in request order.
// Keys live in a single one-read one-write RAM used as a ring; a head
// pointer marks the front slot, so inserts touch one entry.
// Inserts (also into a full list), no-ops and deletes on an empty list go
// from acceptance straight to the result state, then to the output register.
// Deletes walk the RAM one entry per cycle through its read port: the
// search visits entries up to the match, then the tail moves up one slot,
// and the response is then presented from the result state.
// A new request is accepted while a finished response is still held in the
// output register; requests stall while the unit works on one and while
// its finished response waits.
// When rsp_stall is high the response holds and a further finished
// response waits inside the unit until the register frees up.
// Reset empties the list; RAM contents are not cleared.
module ordered_key_list_insert_delete_unit
  import okl_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  logic [OP_W-1:0]     operation,
  input  logic [KEY_W-1:0]    key,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output logic [STATUS_W-1:0] status,
  output logic [COUNT_W-1:0]  count,
  output logic [KEY_W-1:0]    front_key,
  output logic [KEY_W-1:0]    back_key
);

  logic               res_valid;
  logic               res_take;
  result_t            res;
  logic [CW+COUNT_W-1:0] count_ext;

  okl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_op    (op_e_t'(operation)),
    .req_key   (key),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  assign res_take  = res_valid && (!rsp_valid || !rsp_stall);
  assign count_ext = {{COUNT_W{1'b0}}, res.count};

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_take) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      status    <= res.status;
      count     <= count_ext[COUNT_W-1:0];
      front_key <= res.front_key;
      back_key  <= res.back_key;
    end
  end

endmodule

FILE: sim/ordered_key_list_response_checker.sv
`timescale 1ns / 100ps

module ordered_key_list_response_checker
  import okl_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  logic                req_stall,
  input  logic [OP_W-1:0]     operation,
  input  logic [KEY_W-1:0]    key,
  input  logic                rsp_valid,
  input  logic                rsp_stall,
  input  logic [STATUS_W-1:0] status,
  input  logic [COUNT_W-1:0]  count,
  input  logic [KEY_W-1:0]    front_key,
  input  logic [KEY_W-1:0]    back_key,
  output int                  errors,
  output int                  pending
);

  typedef struct {
    status_e_t          status;
    logic [COUNT_W-1:0] count;
    logic [KEY_W-1:0]   front_key;
    logic [KEY_W-1:0]   back_key;
  } list_rsp_t;

  logic [KEY_W-1:0] model_keys[$];
  list_rsp_t        expected_rsp_q[$];
  int               mismatch_cnt = 0;

  assign errors = mismatch_cnt;

  task automatic report_mismatch(input string what, input logic [KEY_W-1:0] exp_v,
                                 input logic [KEY_W-1:0] got_v);
    if (mismatch_cnt < 100) begin
      $display("%0t ns: mismatch on %s: expected %h, got %h", $time, what, exp_v, got_v);
    end
    mismatch_cnt++;
  endtask

  task automatic predict_list_op(input op_e_t op, input logic [KEY_W-1:0] k,
                                 output list_rsp_t r);
    int hit;
    hit = -1;
    r.status = STS_DONE;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (model_keys.size() >= LIST_DEPTH) begin
          r.status = STS_FULL;
        end else if (op == OP_PUSH_FRONT) begin
          model_keys.push_front(k);
        end else begin
          model_keys.push_back(k);
        end
      end
      OP_DELETE: begin
        if (model_keys.size() == 0) begin
          r.status = STS_EMPTY;
        end else begin
          for (int i = 0; i < model_keys.size(); i++) begin
            if (hit < 0 && model_keys[i] == k) begin
              hit = i;
            end
          end
          if (hit < 0) begin
            r.status = STS_NOT_FOUND;
          end else begin
            model_keys.delete(hit);
          end
        end
      end
      default: ;
    endcase
    r.count = COUNT_W'(model_keys.size());
    if (model_keys.size() == 0) begin
      r.front_key = '0;
      r.back_key  = '0;
    end else begin
      r.front_key = model_keys[0];
      r.back_key  = model_keys[model_keys.size() - 1];
    end
  endtask

  always @(posedge clk) begin : watch
    list_rsp_t e;
    if (rst) begin
      model_keys.delete();
      expected_rsp_q.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsp_q.size() == 0) begin
          report_mismatch("unexpected response status", '0, KEY_W'(status));
        end else begin
          e = expected_rsp_q.pop_front();
          if (status !== e.status) begin
            report_mismatch("status", KEY_W'(e.status), KEY_W'(status));
          end
          if (count !== e.count) begin
            report_mismatch("count", KEY_W'(e.count), KEY_W'(count));
          end
          if (front_key !== e.front_key) begin
            report_mismatch("front_key", e.front_key, front_key);
          end
          if (back_key !== e.back_key) begin
            report_mismatch("back_key", e.back_key, back_key);
          end
        end
      end
      if (req_valid && !req_stall) begin
        predict_list_op(op_e_t'(operation), key, e);
        expected_rsp_q.push_back(e);
      end
    end
    pending <= expected_rsp_q.size();
  end

endmodule

FILE: sim/ordered_key_list_insert_delete_unit_tb.sv
`timescale 1ns / 100ps

module ordered_key_list_insert_delete_unit_tb
  import okl_pkg::*;
();

  localparam int IDLE_LIMIT     = 3000;
  localparam int HOLD_CYCLES    = 300;
  localparam int HOLD_AFTER_RSP = 150;
  localparam int RANDOM_ITEMS   = 450;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                req_valid = 1'b0;
  logic                req_stall;
  logic [OP_W-1:0]     operation = '0;
  logic [KEY_W-1:0]    key = '0;
  logic                rsp_valid;
  logic                rsp_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  count;
  logic [KEY_W-1:0]    front_key;
  logic [KEY_W-1:0]    back_key;

  int               errors;
  int               pending;
  int               idle_cycles = 0;
  bit               send_burst = 1'b0;
  logic [KEY_W-1:0] recent_keys[8];
  int               recent_wr = 0;

  always #6 clk = ~clk;

  ordered_key_list_insert_delete_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .operation (operation),
    .key       (key),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .status    (status),
    .count     (count),
    .front_key (front_key),
    .back_key  (back_key)
  );

  ordered_key_list_response_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .operation (operation),
    .key       (key),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .status    (status),
    .count     (count),
    .front_key (front_key),
    .back_key  (back_key),
    .errors    (errors),
    .pending   (pending)
  );

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // hold the payload until the transaction is accepted
  task automatic send_item(input op_e_t op, input logic [KEY_W-1:0] k);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    operation <= op;
    key       <= k;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK) begin
      recent_keys[recent_wr % 8] = k;
      recent_wr++;
    end
  endtask

  function automatic logic [KEY_W-1:0] pick_insert_key();
    logic [KEY_W-1:0] k;
    case ($urandom_range(0, 3))
      0: k = KEY_W'($urandom_range(0, 7));
      1: begin
        case ($urandom_range(0, 3))
          0: k = 32'h7fff_ffff;
          1: k = 32'h8000_0000;
          2: k = 32'h0000_0000;
          default: k = 32'hffff_ffff;
        endcase
      end
      default: k = $urandom;
    endcase
    return k;
  endfunction

  // receiver: random hold-offs, one long one to back up the unit
  initial begin : receiver
    int n_rsp;
    int gap;
    bit burst;
    n_rsp = 0;
    burst = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (n_rsp % 32 == 31) begin
        burst = ($urandom_range(0, 2) == 0);
      end
      if (n_rsp == HOLD_AFTER_RSP) begin
        gap = HOLD_CYCLES;
      end else begin
        gap = burst ? 0 : $urandom_range(0, 16);
      end
      if (gap > 0) begin
        rsp_stall <= 1'b1;
        repeat (gap) @(posedge clk);
        rsp_stall <= 1'b0;
      end
      @(posedge clk);
      while (!rsp_valid) @(posedge clk);
      n_rsp++;
    end
  end

  initial begin : stimulus
    int r;
    int push_w;
    op_e_t op;
    logic [KEY_W-1:0] k;
    foreach (recent_keys[i]) recent_keys[i] = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(OP_DELETE, 32'd5);
    send_item(OP_NOP, 32'd0);
    send_item(OP_PUSH_FRONT, 32'h7fff_ffff);
    send_item(OP_DELETE, 32'h7fff_ffff);
    send_item(OP_PUSH_BACK, 32'h8000_0000);
    send_item(OP_PUSH_FRONT, 32'h0000_0000);
    send_item(OP_PUSH_BACK, 32'hffff_ffff);
    send_item(OP_DELETE, 32'd123);
    for (int i = 0; i < 13; i++) begin
      send_item((i % 2) ? OP_PUSH_BACK : OP_PUSH_FRONT, KEY_W'(i % 5));
    end
    send_item(OP_PUSH_FRONT, 32'd1);
    send_item(OP_PUSH_BACK, 32'd2);
    send_item(OP_DELETE, 32'd3);
    send_item(OP_NOP, 32'hffff_ffff);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 32 == 0) begin
        send_burst = ($urandom_range(0, 2) == 0);
      end
      case ((i / 40) % 3)
        0: push_w = 66;
        1: push_w = 26;
        default: push_w = 46;
      endcase
      r = $urandom_range(0, 99);
      if (r < 4) begin
        op = OP_NOP;
        k  = $urandom;
      end else if (r < 4 + push_w) begin
        op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
        k  = pick_insert_key();
      end else begin
        op = OP_DELETE;
        k  = ($urandom_range(0, 9) < 7) ? recent_keys[$urandom_range(0, 7)]
                                         : pick_insert_key();
      end
      send_item(op, k);
    end
    req_valid <= 1'b0;
    @(posedge clk);

    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
